// ----- rtl/core/npfd_pkg.sv -----
// Package for the nibble pair frame deframer.
// Register reset values, register indexes, frame kind codes and shared types.
// No dependencies.
package npfd_pkg;

  localparam int COUNT_BITS_DEF = 17;
  localparam int LEN_W          = 17;
  localparam int RUN_W          = 6;
  localparam int MARK_W         = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 17;

  localparam logic [7:0]        SYNC_BYTE_RST    = 8'd65;
  localparam logic [RUN_W-1:0]  SYNC_RUN_RST     = 6'd16;
  localparam logic [MARK_W-1:0] MARKER_PAIRS_RST = 5'd8;
  localparam logic [LEN_W-1:0]  HIGH_MIN_RST     = 17'd79544;
  localparam logic [LEN_W-1:0]  LOW_MIN_RST      = 17'd20008;
  localparam logic [LEN_W-1:0]  LOW_MAX_RST      = 17'd79000;
  localparam logic [LEN_W-1:0]  LEN_MAX          = 17'h1FFFF;
  localparam logic [RUN_W-1:0]  RUN_MAX          = 6'd63;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE    = 3'd0,
    CFG_SYNC_RUN     = 3'd1,
    CFG_MARKER_PAIRS = 3'd2,
    CFG_HIGH_MIN     = 3'd3,
    CFG_LOW_MIN      = 3'd4,
    CFG_LOW_MAX      = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LOW  = 2'd1,
    KIND_HIGH = 2'd2
  } frame_kind_t;

  // classifier verdict for a closing frame
  typedef struct packed {
    logic        accept;
    frame_kind_t kind;
  } frame_class_t;

endpackage

// ----- rtl/core/npfd_classify.sv -----
// Frame classifier: net length (count less marker pairs) against the windows.
// Depends on npfd_pkg.
module npfd_classify import npfd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] count,
  input  logic [MARK_W-1:0]     marker_pairs,
  input  logic [LEN_W-1:0]      high_frame_min,
  input  logic [LEN_W-1:0]      low_frame_min,
  input  logic [LEN_W-1:0]      low_frame_max,
  output frame_class_t          verdict
);

  localparam int W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  logic [W-1:0] net;
  logic         long_enough;
  logic         is_high;
  logic         is_low;

  assign long_enough = count >= COUNT_BITS'(marker_pairs);
  assign net         = W'(count) - W'(marker_pairs);
  assign is_high     = net >= W'(high_frame_min);
  assign is_low      = (net >= W'(low_frame_min)) && (net < W'(low_frame_max));

  always_comb begin
    verdict.accept = 1'b0;
    verdict.kind   = KIND_NONE;
    if (long_enough) begin
      if (is_high) begin
        verdict.accept = 1'b1;
        verdict.kind   = KIND_HIGH;
      end else if (is_low) begin
        verdict.accept = 1'b1;
        verdict.kind   = KIND_LOW;
      end
    end
  end

endmodule

// ----- rtl/core/nibble_pair_frame_deframer.sv -----
// Nibble pair frame deframer, top level.
// Byte input register, sync hunt / pairing / frame close logic, result register.
// Depends on npfd_pkg and npfd_classify.
//
// channel   dir  transaction
// s_axis    in   one received byte: tdata[7:0] data_byte
// m_axis    out  one pixel per byte pair: tdata pixel + frame_length, tlast frame_end,
//                tuser frame_kind
// cfg       in   register write: cfg_we, cfg_index, cfg_data (no read-back)
//
// One byte per cycle sustained while m_axis does not stall; a byte is held in the
// input register and its pixel (on the second byte of a pair) then moves into the
// result register, which drives m_axis tvalid; an s_axis byte thus passes both
// registers before its pixel reaches m_axis.
// Reset (rst, synchronous) returns to hunting with counters cleared and
// registers at their default values.
// When m_axis stalls, the input register holds one more byte; s_axis tready
// drops only when both registers are full.
module nibble_pair_frame_deframer import npfd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [7:0] pixel, [24:8] frame_length, rest 0
  output logic                  m_axis_tlast,   // frame_end
  output logic [1:0]            m_axis_tuser,   // [1:0] frame_kind
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int                    W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  // configuration registers
  logic [7:0]        sync_byte;
  logic [RUN_W-1:0]  sync_run_length;
  logic [MARK_W-1:0] marker_pairs;
  logic [LEN_W-1:0]  high_frame_min;
  logic [LEN_W-1:0]  low_frame_min;
  logic [LEN_W-1:0]  low_frame_max;

  // deframer state
  logic                  locked, locked_next;
  logic [RUN_W-1:0]      run_count, run_count_next;
  logic                  pair_phase, pair_phase_next;
  logic [7:0]            held_byte, held_byte_next;
  logic [COUNT_BITS-1:0] pixel_count, pixel_count_next;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // result register
  logic             out_valid;
  logic [7:0]       out_pixel;
  logic             out_end;
  frame_kind_t      out_kind;
  logic [LEN_W-1:0] out_len;

  logic             emit;
  logic [7:0]       pixel_next;
  logic             end_next;
  frame_kind_t      kind_next;
  logic [LEN_W-1:0] len_next;

  logic                  advance;
  logic                  sync_hit;
  logic [RUN_W-1:0]      run_inc;
  logic [RUN_W-1:0]      run_hit;
  logic [RUN_W-1:0]      need_run;
  logic [RUN_W-1:0]      need_mark;
  logic [COUNT_BITS-1:0] pc_inc;
  frame_class_t          verdict;

  // the input byte moves on when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign sync_hit  = in_byte == sync_byte;
  assign run_inc   = (run_count == RUN_MAX) ? run_count : run_count + RUN_W'(1);
  assign need_run  = (sync_run_length == '0) ? RUN_W'(1) : sync_run_length;
  assign need_mark = (marker_pairs == '0) ? RUN_W'(1) : RUN_W'(marker_pairs);
  assign pc_inc    = (pixel_count == COUNT_MAX) ? pixel_count
                                                : pixel_count + COUNT_BITS'(1);

  npfd_classify #(
    .COUNT_BITS(COUNT_BITS)
  ) u_classify (
    .count          (pc_inc),
    .marker_pairs   (marker_pairs),
    .high_frame_min (high_frame_min),
    .low_frame_min  (low_frame_min),
    .low_frame_max  (low_frame_max),
    .verdict        (verdict)
  );

  always_comb begin
    locked_next      = locked;
    run_count_next   = run_count;
    pair_phase_next  = pair_phase;
    held_byte_next   = held_byte;
    pixel_count_next = pixel_count;
    run_hit          = '0;
    emit             = 1'b0;
    pixel_next       = {held_byte[3:0], in_byte[3:0]};
    end_next         = 1'b0;
    kind_next        = KIND_NONE;
    len_next         = '0;

    if (!locked) begin
      // hunting: count consecutive sync bytes
      run_hit = sync_hit ? run_inc : '0;
      run_count_next = run_hit;
      if (run_hit >= need_run) begin
        locked_next     = 1'b1;
        run_count_next  = '0;
        pair_phase_next = 1'b0;
      end
    end else if (!pair_phase) begin
      held_byte_next  = in_byte;
      pair_phase_next = 1'b1;
    end else begin
      pair_phase_next  = 1'b0;
      emit             = 1'b1;
      // marker pair: both bytes equal the sync byte
      run_hit          = ((held_byte == sync_byte) && sync_hit) ? run_inc : '0;
      run_count_next   = run_hit;
      pixel_count_next = pc_inc;
      if (run_hit >= need_mark) begin
        run_count_next = '0;
        if (verdict.accept) begin
          end_next         = 1'b1;
          kind_next        = verdict.kind;
          len_next         = (W'(pc_inc) > W'(LEN_MAX)) ? LEN_MAX : LEN_W'(pc_inc);
          pixel_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte       <= SYNC_BYTE_RST;
      sync_run_length <= SYNC_RUN_RST;
      marker_pairs    <= MARKER_PAIRS_RST;
      high_frame_min  <= HIGH_MIN_RST;
      low_frame_min   <= LOW_MIN_RST;
      low_frame_max   <= LOW_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:    sync_byte       <= cfg_data[7:0];
        CFG_SYNC_RUN:     sync_run_length <= cfg_data[RUN_W-1:0];
        CFG_MARKER_PAIRS: marker_pairs    <= cfg_data[MARK_W-1:0];
        CFG_HIGH_MIN:     high_frame_min  <= cfg_data[LEN_W-1:0];
        CFG_LOW_MIN:      low_frame_min   <= cfg_data[LEN_W-1:0];
        CFG_LOW_MAX:      low_frame_max   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      locked      <= 1'b0;
      run_count   <= '0;
      pair_phase  <= 1'b0;
      held_byte   <= '0;
      pixel_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        locked      <= locked_next;
        run_count   <= run_count_next;
        pair_phase  <= pair_phase_next;
        held_byte   <= held_byte_next;
        pixel_count <= pixel_count_next;
        out_valid   <= emit;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance && emit) begin
      out_pixel <= pixel_next;
      out_end   <= end_next;
      out_kind  <= kind_next;
      out_len   <= len_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_len, out_pixel};
  assign m_axis_tlast  = out_end;
  assign m_axis_tuser  = out_kind;

endmodule
